@@ src/pcm_pkg.sv @@
// Shared types and constants for the three-mode PID controller.
package pcm_pkg;

   localparam int GAIN_W     = 16;
   localparam int DRIVE_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

   // Mode codes; code 2 (raw increment) and the unused code 3 take the default path.
   localparam logic [1:0] MODE_POSITIONAL  = 2'd0;
   localparam logic [1:0] MODE_INCREMENTAL = 2'd1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODE         = 3'd0,
      CSR_GAIN_P       = 3'd1,
      CSR_GAIN_I       = 3'd2,
      CSR_GAIN_D       = 3'd3,
      CSR_INTEGRAL_MAX = 3'd4,
      CSR_INTEGRAL_MIN = 3'd5,
      CSR_DRIVE_MAX    = 3'd6,
      CSR_DRIVE_MIN    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                 mode;
      logic signed [GAIN_W-1:0]   gain_p;
      logic signed [GAIN_W-1:0]   gain_i;
      logic signed [GAIN_W-1:0]   gain_d;
      logic signed [DRIVE_W-1:0]  integral_max;
      logic signed [DRIVE_W-1:0]  integral_min;
      logic signed [DRIVE_W-1:0]  drive_max;
      logic signed [DRIVE_W-1:0]  drive_min;
   } pcm_cfg_type;

endpackage

@@ src/pcm_csr.sv @@
// Configuration register file of the PID controller.
module pcm_csr import pcm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_ADDR_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output pcm_cfg_type            cfg
);

   pcm_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:         cfg_in.mode         = csr_wdata[1:0];
            CSR_GAIN_P:       cfg_in.gain_p       = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:       cfg_in.gain_i       = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:       cfg_in.gain_d       = csr_wdata[GAIN_W-1:0];
            CSR_INTEGRAL_MAX: cfg_in.integral_max = csr_wdata[DRIVE_W-1:0];
            CSR_INTEGRAL_MIN: cfg_in.integral_min = csr_wdata[DRIVE_W-1:0];
            CSR_DRIVE_MAX:    cfg_in.drive_max    = csr_wdata[DRIVE_W-1:0];
            CSR_DRIVE_MIN:    cfg_in.drive_min    = csr_wdata[DRIVE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= MODE_POSITIONAL;
         cfg_ff.gain_p       <= '0;
         cfg_ff.gain_i       <= '0;
         cfg_ff.gain_d       <= '0;
         cfg_ff.integral_max <= DRIVE_MAX;
         cfg_ff.integral_min <= DRIVE_MIN;
         cfg_ff.drive_max    <= DRIVE_MAX;
         cfg_ff.drive_min    <= DRIVE_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/pcm_core.sv @@
// PID datapath: error history, integrator, three gain products and output clamps.
module pcm_core import pcm_pkg::*; #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic signed [SAMPLE_WIDTH-1:0] measured,
   input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
   input  pcm_cfg_type                    cfg,
   output logic signed [DRIVE_W-1:0]      drive
);

   localparam int EW    = SAMPLE_WIDTH + 1;
   localparam int DW1   = EW + 1;
   localparam int DW2   = EW + 2;
   localparam int IW    = (DRIVE_W > EW) ? DRIVE_W : EW;
   localparam int CW    = IW + 1;
   localparam int PPW   = GAIN_W + DW1;
   localparam int PIW   = GAIN_W + IW;
   localparam int PDW   = GAIN_W + DW2;
   localparam int ACC_W = ((PIW > PDW) ? PIW : PDW) + 2;

   logic signed [DRIVE_W-1:0] error_sum_ff, error_sum_in;
   logic signed [DRIVE_W-1:0] held_drive_ff, held_drive_in;
   logic signed [EW-1:0]      last_error_ff, prior_error_ff;
   logic signed [EW-1:0]      err;
   logic signed [DW1-1:0]     diff1;
   logic signed [DW2-1:0]     diff2;
   logic signed [CW-1:0]      sum_raw, held_raw;
   logic signed [DRIVE_W-1:0] sum_clamped;
   logic                      positional;
   logic signed [DW1-1:0]     op_p;
   logic signed [IW-1:0]      op_i;
   logic signed [DW2-1:0]     op_d;
   logic signed [PPW-1:0]     prod_p;
   logic signed [PIW-1:0]     prod_i;
   logic signed [PDW-1:0]     prod_d;
   logic signed [ACC_W-1:0]   acc, acc_shr;
   logic [ACC_W-DRIVE_W:0]    acc_top;
   logic signed [DRIVE_W-1:0] ctl_sat, pos_drive, inc_drive;

   // upper limit first, then lower: an inverted pair yields the lower limit
   function automatic logic signed [DRIVE_W-1:0] clamp_fn(
      input logic signed [CW-1:0]      x,
      input logic signed [DRIVE_W-1:0] hi,
      input logic signed [DRIVE_W-1:0] lo
   );
      logic signed [CW-1:0] y;
      y = x;
      if (y >= CW'(hi)) y = CW'(hi);
      if (y <= CW'(lo)) y = CW'(lo);
      return y[DRIVE_W-1:0];
   endfunction

   assign err   = EW'(setpoint) - EW'(measured);
   assign diff1 = DW1'(err) - DW1'(last_error_ff);
   assign diff2 = DW2'(err) - (DW2'(last_error_ff) <<< 1) + DW2'(prior_error_ff);

   assign sum_raw     = CW'(error_sum_ff) + CW'(err);
   assign sum_clamped = clamp_fn(sum_raw, cfg.integral_max, cfg.integral_min);

   // multipliers shared between the positional and incremental forms
   assign positional = (cfg.mode == MODE_POSITIONAL);
   assign op_p = positional ? DW1'(err) : diff1;
   assign op_i = positional ? IW'(sum_clamped) : IW'(err);
   assign op_d = positional ? DW2'(diff1) : diff2;

   assign prod_p = PPW'(cfg.gain_p) * PPW'(op_p);
   assign prod_i = PIW'(cfg.gain_i) * PIW'(op_i);
   assign prod_d = PDW'(cfg.gain_d) * PDW'(op_d);

   assign acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
   assign acc_shr = acc >>> GAIN_FRAC_BITS;
   assign acc_top = acc_shr[ACC_W-1:DRIVE_W-1];

   always_comb begin
      if ((&acc_top) || ~(|acc_top)) begin
         ctl_sat = acc_shr[DRIVE_W-1:0];
      end else if (acc_shr[ACC_W-1]) begin
         ctl_sat = DRIVE_MIN;
      end else begin
         ctl_sat = DRIVE_MAX;
      end
   end

   assign pos_drive = clamp_fn(CW'(ctl_sat), cfg.drive_max, cfg.drive_min);
   assign held_raw  = CW'(held_drive_ff) + CW'(ctl_sat);
   assign inc_drive = clamp_fn(held_raw, cfg.drive_max, cfg.drive_min);

   always_comb begin
      error_sum_in  = error_sum_ff;
      held_drive_in = held_drive_ff;
      drive         = ctl_sat;
      case (cfg.mode)
         MODE_POSITIONAL: begin
            error_sum_in  = sum_clamped;
            held_drive_in = pos_drive;
            drive         = pos_drive;
         end
         MODE_INCREMENTAL: begin
            held_drive_in = inc_drive;
            drive         = inc_drive;
         end
         default: begin
            // raw increment: output the saturated increment, hold state
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff   <= '0;
         held_drive_ff  <= '0;
         last_error_ff  <= '0;
         prior_error_ff <= '0;
      end else if (step) begin
         error_sum_ff   <= error_sum_in;
         held_drive_ff  <= held_drive_in;
         last_error_ff  <= err;
         prior_error_ff <= last_error_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_sum_in_limits: assert property (@(posedge clock) disable iff (reset)
      step && positional && (cfg.integral_min <= cfg.integral_max)
      |=> (error_sum_ff <= $past(cfg.integral_max)) &&
          (error_sum_ff >= $past(cfg.integral_min)))
      else $error("integrator left its limits");
   a_raw_holds: assert property (@(posedge clock) disable iff (reset)
      step && (cfg.mode != MODE_POSITIONAL) && (cfg.mode != MODE_INCREMENTAL)
      |=> $stable(held_drive_ff) && $stable(error_sum_ff))
      else $error("raw mode changed held state");
   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      step |=> prior_error_ff == $past(last_error_ff))
      else $error("error history did not shift");
`endif

endmodule

@@ src/pid_controller_three_mode_top.sv @@
// Top level of the three-mode PID controller: stream handshakes and stage registers.
// A req_ transfer reaches rsp_tvalid through the input register, then the result register.
// Throughput: one sample per cycle while rsp_tready is high; the register-to-register loop
//   through the integrator, the gain multipliers and the held-output adder sets the clock.
// Reset (synchronous, active high): stages empty, error history, integrator and held
//   output zero, gains zero, mode positional, all limits at the full 32-bit range.
// The csr_ port is always ready; write it only while no sample is in flight.
module pid_controller_three_mode_top import pcm_pkg::*; #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata, // measured, setpoint
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DRIVE_W-1:0]     rsp_tdata,             // drive
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_ADDR_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   pcm_cfg_type cfg;

   logic                           in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] measured_ff, setpoint_ff;
   logic                           out_valid_ff;
   logic signed [DRIVE_W-1:0]      drive_ff, drive_in;
   logic                           advance;

   pcm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // the input stage moves on when the result register is empty or drains this cycle
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = drive_ff;

   pcm_core #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .measured (measured_ff),
      .setpoint (setpoint_ff),
      .cfg      (cfg),
      .drive    (drive_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         measured_ff <= req_tdata[SAMPLE_WIDTH-1:0];
         setpoint_ff <= req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff <= drive_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("computed sample did not reach the result register");
   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_tready && !advance |=> !out_valid_ff)
      else $error("result transfer repeated");
   a_req_loads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> in_valid_ff)
      else $error("accepted sample lost at the input register");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_tready)
      else $error("input register would be overwritten");
`endif

endmodule
